// File: rtl/uksl_pkg.sv
package uksl_pkg;

  // built table depth and derived widths
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned CAP_W    = 6;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SLOT_FW  = 5;
  localparam int unsigned COUNT_FW = 6;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 16;

  // command codes; the unused code behaves as a query
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

  typedef struct packed {
    logic              en;
    logic              set;   // 1: store key, 0: clear slot
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
  } wr_req_t;

  typedef struct packed {
    logic              ok;
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

// File: rtl/uksl_store.sv
module uksl_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [uksl_pkg::SLOT_W-1:0]  rd_addr_i,
  output logic [uksl_pkg::KEY_W-1:0]   rd_data_o,
  input  uksl_pkg::wr_req_t            wr_i
);
  import uksl_pkg::*;

  logic [KEY_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [KEY_W-1:0]       rd_data_q;
  logic                   rd_vld_q;

  // key array, no reset; emptiness lives in the valid bits
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      mem[wr_i.addr] <= wr_i.key;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= wr_i.set;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // an empty slot reads as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: rtl/uksl_ctrl.sv
module uksl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [uksl_pkg::CMD_W-1:0]   in_cmd_i,
  input  logic [uksl_pkg::KEY_W-1:0]   in_key_i,
  input  logic [uksl_pkg::CAP_W-1:0]   cap_i,
  input  logic                         out_free_i,
  output logic                         res_valid_o,
  output uksl_pkg::result_t            res_o,
  output logic                         rd_en_o,
  output logic [uksl_pkg::SLOT_W-1:0]  rd_addr_o,
  input  logic [uksl_pkg::KEY_W-1:0]   rd_data_i,
  output uksl_pkg::wr_req_t            wr_o
);
  import uksl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rvld_q, rvld_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic              emp_found_q, emp_found_d;
  logic [SLOT_W-1:0] emp_slot_q, emp_slot_d;
  result_t           res_q, res_d;

  logic [CNT_W-1:0]  lim;
  logic              hit, empty, is_ins, is_rem;

  // slots in use: capacity clipped to the built depth
  always_comb begin
    if (int'(cap_i) > TABLE_DEPTH) begin
      lim = CNT_W'(TABLE_DEPTH);
    end else begin
      lim = CNT_W'(cap_i);
    end
  end

  assign is_ins = (cmd_q == CMD_INSERT);
  assign is_rem = (cmd_q == CMD_REMOVE);
  // key-match and empty-slot compares on the registered read data
  assign hit    = rvld_q && (rd_data_i == key_q);
  assign empty  = rvld_q && (rd_data_i == '0);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    rvld_d      = 1'b0;
    rslot_d     = rslot_q;
    emp_found_d = emp_found_q;
    emp_slot_d  = emp_slot_q;
    res_d       = res_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[SLOT_W-1:0];
    wr_o        = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = in_cmd_i;
          key_d       = in_key_i;
          idx_d       = '0;
          emp_found_d = 1'b0;
          res_d       = '{ok: 1'b0, status: ST_OK, slot: '0, count: occ_q};
          if (in_key_i == '0) begin
            res_d.status = ST_INVALID;
            state_d      = S_DONE;
          end else if (in_cmd_i == CMD_INSERT && occ_q >= lim) begin
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_d = S_DONE;
          if (is_ins) begin
            res_d.status = ST_DUP;
          end else begin
            res_d.ok   = 1'b1;
            res_d.slot = rslot_q;
            if (is_rem) begin
              wr_o.en   = 1'b1;
              wr_o.set  = 1'b0;
              wr_o.addr = rslot_q;
              if (occ_q != '0) begin
                occ_d = occ_q - 1'b1;
              end
            end
            res_d.count = occ_d;
          end
        end else if (!rvld_q && idx_q >= lim) begin
          // scan drained without a match
          state_d = S_DONE;
          if (is_ins) begin
            if (emp_found_q) begin
              wr_o.en     = 1'b1;
              wr_o.set    = 1'b1;
              wr_o.addr   = emp_slot_q;
              wr_o.key    = key_q;
              occ_d       = occ_q + 1'b1;
              res_d.ok    = 1'b1;
              res_d.slot  = emp_slot_q;
              res_d.count = occ_d;
            end else begin
              res_d.status = ST_FULL;
            end
          end else begin
            res_d.status = ST_NOTFOUND;
          end
        end else begin
          if (empty && is_ins && !emp_found_q) begin
            emp_found_d = 1'b1;
            emp_slot_d  = rslot_q;
          end
          if (idx_q < lim) begin
            rd_en_o = 1'b1;
            idx_d   = idx_q + 1'b1;
            rvld_d  = 1'b1;
            rslot_d = idx_q[SLOT_W-1:0];
          end
        end
      end

      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      emp_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      rvld_q      <= rvld_d;
      emp_found_q <= emp_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    rslot_q    <= rslot_d;
    emp_slot_q <= emp_slot_d;
    res_q      <= res_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= TABLE_DEPTH)
    else $error("occupancy above table depth");

  a_wr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en && wr_o.set |-> wr_o.key != '0)
    else $error("zero key written to store");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> idx_q < lim)
    else $error("read beyond active slots");

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result handed off into busy output register");

  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.ok |-> res_o.slot == '0 && res_o.status != ST_OK)
    else $error("failed result with slot or ok status");

endmodule

// File: rtl/unique_key_slot_table.sv
// Channel   Dir  Transaction   Payload
// s_axis    in   command       tuser: cmd[1:0]; tdata: key[30:0], zero pad [31]
// m_axis    out  result        tdata: ok[0], status[3:1], slot[8:4], count[14:9], pad[15]
// cfg       in   write only    cfg_wdata_i: capacity[5:0]
//
// One command at a time. A command scans the active slots (capacity clipped to
// the table depth) through one registered read port, with a key-match compare
// and an empty-slot compare; invalid keys and inserts into a full table skip
// the scan. A hit ends the scan early.
// Reset (async, active low) clears the capacity, the count and the slot valid
// bits at once; no clearing sweep is needed.
// The result sits in an output register, so the next command is accepted while
// a result waits; only a further result stalls the sequencer behind it.
module unique_key_slot_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [uksl_pkg::CMD_W-1:0]    s_axis_tuser_i,  // cmd
  input  logic [uksl_pkg::IN_DW-1:0]    s_axis_tdata_i,  // key, pad
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [uksl_pkg::OUT_DW-1:0]   m_axis_tdata_o,  // ok, status, slot, count, pad
  input  logic                          cfg_we_i,
  input  logic [uksl_pkg::CAP_W-1:0]    cfg_wdata_i
);
  import uksl_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic              m_valid_q;
  logic [OUT_DW-1:0] m_data_q;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;
  wr_req_t           wr;

  // output register is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  uksl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i[KEY_W-1:0]),
    .cap_i       (cap_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (wr)
  );

  uksl_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= {1'b0, COUNT_FW'(res.count), SLOT_FW'(res.slot), res.status, res.ok};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
